// ===== rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros shared by the RTL
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// property checked on every rising clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");
// same-cycle implication
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rst, prop)
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`endif
`endif

// ===== rtl/qccc_pkg.sv =====
// ---------------------------------------------------------------------------
// qccc_pkg
// Shared constants and types of the quad clip cull classifier.
// ---------------------------------------------------------------------------
`default_nettype none
package qccc_pkg;
  localparam int unsigned SUM_W    = 34;  // sum of three 32-bit terms
  localparam int unsigned Q_W      = 32;
  localparam int unsigned DIV_BITS = 32;  // quotient bits, one per stage
  localparam int unsigned DIV_LAT  = DIV_BITS + 2;
  localparam int unsigned CORNERS  = 4;

  // corner k uses column x when CORNER_U[k], column y when CORNER_V[k]
  localparam logic [CORNERS-1:0] CORNER_U = 4'b1100;
  localparam logic [CORNERS-1:0] CORNER_V = 4'b0110;

  localparam logic signed [Q_W-1:0] Q_ONE     = 32'sd65536;
  localparam logic signed [Q_W-1:0] Q_NEG_ONE = -32'sd65536;
  localparam logic signed [Q_W-1:0] Q_MAX     = 32'sh7fff_ffff;
  localparam logic signed [Q_W-1:0] Q_MIN     = 32'sh8000_0000;

  typedef logic [1:0] cull_class_t;
  localparam cull_class_t CLASS_OFF  = 2'd0;
  localparam cull_class_t CLASS_ON   = 2'd1;
  localparam cull_class_t CLASS_FULL = 2'd2;
  localparam cull_class_t CLASS_NONE = 2'd3;
endpackage
`default_nettype wire

// ===== rtl/qccc_div.sv =====
// ---------------------------------------------------------------------------
// qccc_div
// Pipelined signed Q16.16 divide (n << 16) / w, truncated and saturated,
// restoring, one quotient bit per stage.
// ---------------------------------------------------------------------------
`default_nettype none
module qccc_div (
  input  wire logic                                clk,
  input  wire logic                                en,
  input  wire logic signed [qccc_pkg::SUM_W-1:0]   num,
  input  wire logic signed [qccc_pkg::SUM_W-1:0]   den,
  output logic signed [qccc_pkg::Q_W-1:0]          quo
);
  localparam int unsigned SW = qccc_pkg::SUM_W;
  localparam int unsigned NB = qccc_pkg::DIV_BITS;

  logic [SW-1:0] rem  [0:NB];
  logic [SW-1:0] dsr  [0:NB];
  logic [NB-1:0] low  [0:NB];
  logic [NB-1:0] qb   [0:NB];
  logic          neg  [0:NB];
  logic          ovf  [0:NB];
  logic          dz   [0:NB];
  logic          nneg [0:NB];
  logic          nnz  [0:NB];

  logic [SW-1:0] mag_n, mag_d;
  logic          ovf_in;

  always_comb begin
    mag_n  = num[SW-1] ? (~num + SW'(1)) : num;
    mag_d  = den[SW-1] ? (~den + SW'(1)) : den;
    // quotient needs more than 32 bits
    ovf_in = {16'd0, mag_n} >= {mag_d, 16'd0};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0]  <= {16'd0, mag_n[SW-1:16]};
      low[0]  <= {mag_n[15:0], 16'd0};
      dsr[0]  <= mag_d;
      qb[0]   <= '0;
      neg[0]  <= num[SW-1] ^ den[SW-1];
      ovf[0]  <= ovf_in;
      dz[0]   <= (den == '0);
      nneg[0] <= num[SW-1];
      nnz[0]  <= (num != '0);
    end
  end

  for (genvar k = 0; k < NB; k++) begin : g_step
    logic [SW:0]   trial;
    logic          ge;
    logic [SW-1:0] rem_next;
    always_comb begin
      trial    = {rem[k], low[k][NB-1]};
      ge       = trial >= {1'b0, dsr[k]};
      rem_next = ge ? SW'(trial - {1'b0, dsr[k]}) : trial[SW-1:0];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1]  <= rem_next;
        low[k+1]  <= {low[k][NB-2:0], 1'b0};
        qb[k+1]   <= {qb[k][NB-2:0], ge};
        dsr[k+1]  <= dsr[k];
        neg[k+1]  <= neg[k];
        ovf[k+1]  <= ovf[k];
        dz[k+1]   <= dz[k];
        nneg[k+1] <= nneg[k];
        nnz[k+1]  <= nnz[k];
      end
    end
  end

  logic signed [qccc_pkg::Q_W-1:0] quo_next;
  always_comb begin
    if (dz[NB]) begin
      if (!nnz[NB])      quo_next = '0;
      else if (nneg[NB]) quo_next = qccc_pkg::Q_MIN;
      else               quo_next = qccc_pkg::Q_MAX;
    end else if (!neg[NB]) begin
      quo_next = (ovf[NB] || qb[NB][NB-1]) ? qccc_pkg::Q_MAX : qb[NB];
    end else begin
      quo_next = (ovf[NB] || (qb[NB] > 32'h8000_0000)) ? qccc_pkg::Q_MIN
                                                       : (~qb[NB] + 32'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (en) quo <= quo_next;
  end
endmodule
`default_nettype wire

// ===== rtl/quad_clip_cull_classifier_unit.sv =====
// ---------------------------------------------------------------------------
// quad_clip_cull_classifier_unit
// Screen-space bounding box and frustum class of one transformed unit quad.
// ---------------------------------------------------------------------------
// Accepts one request per cycle and returns one result per request, in
// order. The pipeline is the input register, corner sums, a 34-stage
// restoring divider (one quotient bit per stage, eight lanes side by side),
// two min/max stages and the classify/output register. The whole pipeline
// advances when the output register is empty or being taken; otherwise it
// holds, and s_axis_tready is low.
`default_nettype none
`include "assert_macros.svh"
module quad_clip_cull_classifier_unit (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // m_xx, m_xy, m_xw, m_yx, m_yy, m_yw, m_wx, m_wy, m_ww (32 bits each)
  input  wire logic [287:0] s_axis_tdata,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // cull_class[1:0], box_x_min, box_x_max, box_y_min, box_y_max, bad_w, pad
  output logic [135:0]      m_axis_tdata
);
  localparam int unsigned SW = qccc_pkg::SUM_W;
  localparam int unsigned QW = qccc_pkg::Q_W;
  localparam int unsigned NC = qccc_pkg::CORNERS;
  localparam int unsigned DL = qccc_pkg::DIV_LAT;

  logic adv;
  assign adv           = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;

  // stage 0: input register
  logic        v0;
  logic [31:0] m [0:8];
  always_ff @(posedge clk) begin
    if (rst) v0 <= 1'b0;
    else if (adv) v0 <= s_axis_tvalid;
  end
  for (genvar i = 0; i < 9; i++) begin : g_in
    always_ff @(posedge clk) begin
      if (adv) m[i] <= s_axis_tdata[32*i +: 32];
    end
  end

  // stage 1: homogeneous corner values
  logic                 v1, bad1;
  logic signed [SW-1:0] cx [0:NC-1];
  logic signed [SW-1:0] cy [0:NC-1];
  logic signed [SW-1:0] cw [0:NC-1];
  logic [NC-1:0]        wbad;

  for (genvar c = 0; c < NC; c++) begin : g_corner
    logic signed [SW-1:0] sx, sy, sw;
    always_comb begin
      sx = SW'($signed(m[2]));
      sy = SW'($signed(m[5]));
      sw = SW'($signed(m[8]));
      if (qccc_pkg::CORNER_U[c]) begin
        sx = sx + SW'($signed(m[0]));
        sy = sy + SW'($signed(m[3]));
        sw = sw + SW'($signed(m[6]));
      end
      if (qccc_pkg::CORNER_V[c]) begin
        sx = sx + SW'($signed(m[1]));
        sy = sy + SW'($signed(m[4]));
        sw = sw + SW'($signed(m[7]));
      end
      wbad[c] = (sw <= 0);
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        cx[c] <= sx;
        cy[c] <= sy;
        cw[c] <= sw;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (adv) v1 <= v0;
  end
  always_ff @(posedge clk) begin
    if (adv) bad1 <= |wbad;
  end

  // divider lanes
  logic signed [QW-1:0] qx [0:NC-1];
  logic signed [QW-1:0] qy [0:NC-1];
  for (genvar c = 0; c < NC; c++) begin : g_div
    qccc_div u_div_x (.clk(clk), .en(adv), .num(cx[c]), .den(cw[c]), .quo(qx[c]));
    qccc_div u_div_y (.clk(clk), .en(adv), .num(cy[c]), .den(cw[c]), .quo(qy[c]));
  end

  // sideband matched to divider latency
  logic [DL:1] dv;
  logic [DL:1] dbad;
  always_ff @(posedge clk) begin
    if (rst) dv <= '0;
    else if (adv) dv <= {dv[DL-1:1], v1};
  end
  always_ff @(posedge clk) begin
    if (adv) dbad <= {dbad[DL-1:1], bad1};
  end

  // min/max stage 1: corner pairs 0/1 and 2/3
  logic                 v_m1, bad_m1;
  logic signed [QW-1:0] xn [0:1];
  logic signed [QW-1:0] xx [0:1];
  logic signed [QW-1:0] yn [0:1];
  logic signed [QW-1:0] yx [0:1];
  for (genvar p = 0; p < 2; p++) begin : g_pair
    always_ff @(posedge clk) begin
      if (adv) begin
        xn[p] <= (qx[2*p] < qx[2*p+1]) ? qx[2*p] : qx[2*p+1];
        xx[p] <= (qx[2*p] > qx[2*p+1]) ? qx[2*p] : qx[2*p+1];
        yn[p] <= (qy[2*p] < qy[2*p+1]) ? qy[2*p] : qy[2*p+1];
        yx[p] <= (qy[2*p] > qy[2*p+1]) ? qy[2*p] : qy[2*p+1];
      end
    end
  end

  // min/max stage 2
  logic                 v_m2, bad_m2;
  logic signed [QW-1:0] x_min, x_max, y_min, y_max;
  always_ff @(posedge clk) begin
    if (adv) begin
      x_min  <= (xn[0] < xn[1]) ? xn[0] : xn[1];
      x_max  <= (xx[0] > xx[1]) ? xx[0] : xx[1];
      y_min  <= (yn[0] < yn[1]) ? yn[0] : yn[1];
      y_max  <= (yx[0] > yx[1]) ? yx[0] : yx[1];
      bad_m1 <= dbad[DL];
      bad_m2 <= bad_m1;
    end
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      v_m1 <= 1'b0;
      v_m2 <= 1'b0;
    end else if (adv) begin
      v_m1 <= dv[DL];
      v_m2 <= v_m1;
    end
  end

  // classify into the output register
  qccc_pkg::cull_class_t cls;
  always_comb begin
    if (x_max <= qccc_pkg::Q_NEG_ONE || x_min >= qccc_pkg::Q_ONE ||
        y_max <= qccc_pkg::Q_NEG_ONE || y_min >= qccc_pkg::Q_ONE)
      cls = qccc_pkg::CLASS_OFF;
    else if (x_max >= qccc_pkg::Q_ONE && x_min <= qccc_pkg::Q_NEG_ONE &&
             y_max >= qccc_pkg::Q_ONE && y_min <= qccc_pkg::Q_NEG_ONE)
      cls = qccc_pkg::CLASS_FULL;
    else
      cls = qccc_pkg::CLASS_ON;
  end

  always_ff @(posedge clk) begin
    if (rst) m_axis_tvalid <= 1'b0;
    else if (adv) m_axis_tvalid <= v_m2;
  end
  always_ff @(posedge clk) begin
    if (adv) m_axis_tdata <= {5'd0, bad_m2, y_max, y_min, x_max, x_min, cls};
  end

  `ASSERT_ALWAYS(a_class_code, clk, rst,
    !m_axis_tvalid || (m_axis_tdata[1:0] != qccc_pkg::CLASS_NONE))
  `ASSERT_IMPLY(a_full_box, clk, rst,
    m_axis_tvalid && (m_axis_tdata[1:0] == qccc_pkg::CLASS_FULL),
    ($signed(m_axis_tdata[33:2]) <= qccc_pkg::Q_NEG_ONE) &&
    ($signed(m_axis_tdata[65:34]) >= qccc_pkg::Q_ONE))
  `ASSERT_IMPLY(a_box_order, clk, rst, m_axis_tvalid,
    ($signed(m_axis_tdata[33:2]) <= $signed(m_axis_tdata[65:34])) &&
    ($signed(m_axis_tdata[97:66]) <= $signed(m_axis_tdata[129:98])))
endmodule
`default_nettype wire
